// ----- rtl/umec_pkg.sv -----
// Shared types, opcodes and request codes of the universal machine execute core.
package umec_pkg;

    localparam int REG_COUNT = 8;
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int WORD_W    = 32;
    localparam int LI_W      = 25;
    localparam int KIND_W    = 4;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam int DIV_STEPS = WORD_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 136;

    // Opcodes, instruction bits 31:28
    localparam logic [3:0] OP_CMOV  = 4'd0;
    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_STORE = 4'd2;
    localparam logic [3:0] OP_ADD   = 4'd3;
    localparam logic [3:0] OP_MUL   = 4'd4;
    localparam logic [3:0] OP_DIV   = 4'd5;
    localparam logic [3:0] OP_NAND  = 4'd6;
    localparam logic [3:0] OP_HALT  = 4'd7;
    localparam logic [3:0] OP_MAP   = 4'd8;
    localparam logic [3:0] OP_UNMAP = 4'd9;
    localparam logic [3:0] OP_OUT   = 4'd10;
    localparam logic [3:0] OP_IN    = 4'd11;
    localparam logic [3:0] OP_LOADP = 4'd12;
    localparam logic [3:0] OP_LDIMM = 4'd13;

    // Request kinds on the result channel
    localparam logic [KIND_W-1:0] K_NONE  = 4'd0;
    localparam logic [KIND_W-1:0] K_LOAD  = 4'd1;
    localparam logic [KIND_W-1:0] K_STORE = 4'd2;
    localparam logic [KIND_W-1:0] K_MAP   = 4'd3;
    localparam logic [KIND_W-1:0] K_UNMAP = 4'd4;
    localparam logic [KIND_W-1:0] K_OUT   = 4'd5;
    localparam logic [KIND_W-1:0] K_IN    = 4'd6;
    localparam logic [KIND_W-1:0] K_LOADP = 4'd7;
    localparam logic [KIND_W-1:0] K_HALT  = 4'd8;

    // Input item kinds
    localparam logic ACT_EXEC  = 1'b0;
    localparam logic ACT_REPLY = 1'b1;

    typedef struct packed {
        logic              action;
        logic [3:0]        op;
        logic [REG_AW-1:0] ra;
        logic [REG_AW-1:0] rb;
        logic [REG_AW-1:0] rc;
        logic [REG_AW-1:0] li_dst;
        logic [LI_W-1:0]   li_val;
        logic [WORD_W-1:0] reply;
    } t_item;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_qstat;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] sid;
        logic [WORD_W-1:0] soff;
        logic [WORD_W-1:0] sval;
        logic [WORD_W-1:0] pc;
        logic              halted;
        logic              dz;
        logic              awaiting;
    } t_result;

    typedef struct packed {
        logic halted;
        logic pending;
    } t_bstat;

endpackage

// ----- rtl/umec_front.sv -----
// Front end: accept input transfers, split the instruction into fields, hand to the queue.
module umec_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [umec_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    input  umec_pkg::t_qstat               i_qstat,
    output logic                           o_push,
    output umec_pkg::t_item                o_item
);
    import umec_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  accept;

    always_comb begin
        n_item        = '0;
        n_item.action = s_tuser;
        n_item.op     = s_tdata[31:28];
        n_item.ra     = s_tdata[8:6];
        n_item.rb     = s_tdata[5:3];
        n_item.rc     = s_tdata[2:0];
        n_item.li_dst = s_tdata[27:25];
        n_item.li_val = s_tdata[24:0];
        n_item.reply  = s_tdata[63:32];
    end

    assign o_push   = r_valid && !i_qstat.full;
    assign s_tready = !r_valid || !i_qstat.full;
    assign accept   = s_tvalid && s_tready;
    assign o_item   = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- rtl/umec_queue.sv -----
// Short queue of decoded items between the front end and the execute back end.
module umec_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  umec_pkg::t_item  i_item,
    input  logic             i_pop,
    output umec_pkg::t_item  o_item,
    output umec_pkg::t_qstat o_stat
);
    import umec_pkg::*;

    t_item           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_cnt;

    assign o_item           = r_mem[r_rp];
    assign o_stat.not_empty = (r_cnt != '0);
    assign o_stat.full      = (r_cnt == Q_CW'(Q_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ----- rtl/umec_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
module umec_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [umec_pkg::WORD_W-1:0] i_dividend,
    input  logic [umec_pkg::WORD_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [umec_pkg::WORD_W-1:0] o_quotient
);
    import umec_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [WORD_W-1:0] r_quo;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_dvs;
    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   rem_sub;
    logic              ge;

    assign rem_sh  = {r_rem, r_quo[WORD_W-1]};
    assign ge      = (rem_sh >= {1'b0, r_dvs});
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CW'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
            r_quo <= {r_quo[WORD_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/umec_back.sv -----
// Back end: register file, sequencer, machine state and the result register.
module umec_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  umec_pkg::t_qstat i_qstat,
    input  umec_pkg::t_item  i_item,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output umec_pkg::t_result o_result,
    output umec_pkg::t_bstat o_stat
);
    import umec_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_STORE = 2'd2;
    localparam logic [1:0] S_DIV   = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    t_item             r_cur;
    logic [WORD_W-1:0] r_pc;
    logic [WORD_W-1:0] n_pc;
    logic              r_halt;
    logic              n_halt;
    logic              r_pend;
    logic              n_pend;
    logic [REG_AW-1:0] r_pdst;
    logic [REG_AW-1:0] n_pdst;
    logic              r_ovalid;
    t_result           r_out;
    t_result           n_out;
    logic [WORD_W-1:0] r_sav_b;
    logic              save_b;

    // register file: two registered read ports, one write port
    logic [WORD_W-1:0] r_rf [REG_COUNT];
    logic [REG_COUNT-1:0] r_rfv;
    logic [WORD_W-1:0] r_rd0;
    logic [WORD_W-1:0] r_rd1;
    logic              rd_en0;
    logic              rd_en1;
    logic [REG_AW-1:0] rd_a0;
    logic [REG_AW-1:0] rd_a1;
    logic              we;
    logic [REG_AW-1:0] wa;
    logic [WORD_W-1:0] wd;

    logic [2*WORD_W-1:0] mul_full;
    logic                out_free;
    logic                fin;
    logic                div_start;
    logic                div_done;
    logic [WORD_W-1:0]   div_quo;

    umec_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_rd0),
        .i_divisor  (r_rd1),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign mul_full = r_rd0 * r_rd1;
    assign out_free = !r_ovalid || i_ready;

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        rd_en0    = 1'b0;
        rd_en1    = 1'b0;
        rd_a0     = i_item.rb;
        rd_a1     = i_item.rc;
        we        = 1'b0;
        wa        = r_cur.ra;
        wd        = '0;
        fin       = 1'b0;
        div_start = 1'b0;
        save_b    = 1'b0;
        n_pc      = r_pc;
        n_halt    = r_halt;
        n_pend    = r_pend;
        n_pdst    = r_pdst;
        n_out     = '0;
        n_out.kind = K_NONE;

        unique case (r_state)
            S_IDLE: begin
                if (i_qstat.not_empty) begin
                    o_pop   = 1'b1;
                    rd_en0  = 1'b1;
                    rd_en1  = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    priority if (r_halt) begin
                        fin = 1'b1;
                    end else if (r_cur.action == ACT_REPLY) begin
                        fin = 1'b1;
                        if (r_pend) begin
                            we     = 1'b1;
                            wa     = r_pdst;
                            wd     = r_cur.reply;
                            n_pend = 1'b0;
                        end
                    end else if (r_pend) begin
                        fin = 1'b1;
                    end else begin
                        fin  = 1'b1;
                        n_pc = r_pc + 32'd1;
                        unique case (r_cur.op)
                            OP_CMOV: begin
                                we = (r_rd1 != '0);
                                wd = r_rd0;
                            end
                            OP_LOAD: begin
                                n_out.kind = K_LOAD;
                                n_out.sid  = r_rd0;
                                n_out.soff = r_rd1;
                                n_pend     = 1'b1;
                                n_pdst     = r_cur.ra;
                            end
                            OP_STORE: begin
                                // third operand: fetch r[a], keep r[b]
                                fin     = 1'b0;
                                n_pc    = r_pc;
                                save_b  = 1'b1;
                                rd_en0  = 1'b1;
                                rd_a0   = r_cur.ra;
                                n_state = S_STORE;
                            end
                            OP_ADD: begin
                                we = 1'b1;
                                wd = r_rd0 + r_rd1;
                            end
                            OP_MUL: begin
                                we = 1'b1;
                                wd = mul_full[WORD_W-1:0];
                            end
                            OP_DIV: begin
                                if (r_rd1 == '0) begin
                                    we       = 1'b1;
                                    wd       = '0;
                                    n_out.dz = 1'b1;
                                end else begin
                                    fin       = 1'b0;
                                    n_pc      = r_pc;
                                    div_start = 1'b1;
                                    n_state   = S_DIV;
                                end
                            end
                            OP_NAND: begin
                                we = 1'b1;
                                wd = ~(r_rd0 & r_rd1);
                            end
                            OP_HALT: begin
                                n_out.kind = K_HALT;
                                n_halt     = 1'b1;
                                n_pc       = r_pc;
                            end
                            OP_MAP: begin
                                n_out.kind = K_MAP;
                                n_out.sid  = r_rd1;
                                n_pend     = 1'b1;
                                n_pdst     = r_cur.rb;
                            end
                            OP_UNMAP: begin
                                n_out.kind = K_UNMAP;
                                n_out.sid  = r_rd1;
                            end
                            OP_OUT: begin
                                n_out.kind = K_OUT;
                                n_out.sval = {24'd0, r_rd1[7:0]};
                            end
                            OP_IN: begin
                                n_out.kind = K_IN;
                                n_pend     = 1'b1;
                                n_pdst     = r_cur.rc;
                            end
                            OP_LOADP: begin
                                if (r_rd0 != '0) begin
                                    n_out.kind = K_LOADP;
                                    n_out.sid  = r_rd0;
                                end
                                n_pc = r_rd1;
                            end
                            OP_LDIMM: begin
                                we = 1'b1;
                                wa = r_cur.li_dst;
                                wd = {{(WORD_W - LI_W){1'b0}}, r_cur.li_val};
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_STORE: begin
                if (out_free) begin
                    fin        = 1'b1;
                    n_pc       = r_pc + 32'd1;
                    n_out.kind = K_STORE;
                    n_out.sid  = r_rd0;
                    n_out.soff = r_sav_b;
                    n_out.sval = r_rd1;
                end
            end
            S_DIV: begin
                if (div_done && out_free) begin
                    fin  = 1'b1;
                    n_pc = r_pc + 32'd1;
                    we   = 1'b1;
                    wd   = div_quo;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state = S_IDLE;
        end
        n_out.pc       = n_pc;
        n_out.halted   = n_halt;
        n_out.awaiting = n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= '0;
            r_halt   <= 1'b0;
            r_pend   <= 1'b0;
            r_pdst   <= '0;
            r_ovalid <= 1'b0;
            r_rfv    <= '0;
        end else begin
            r_state <= n_state;
            if (fin) begin
                r_pc   <= n_pc;
                r_halt <= n_halt;
                r_pend <= n_pend;
                r_pdst <= n_pdst;
            end
            if (fin) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (we) begin
                r_rfv[wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_item;
        end
        if (fin) begin
            r_out <= n_out;
        end
        if (save_b) begin
            r_sav_b <= r_rd0;
        end
        if (we) begin
            r_rf[wa] <= wd;
        end
        if (rd_en0) begin
            r_rd0 <= r_rfv[rd_a0] ? r_rf[rd_a0] : '0;
        end
        if (rd_en1) begin
            r_rd1 <= r_rfv[rd_a1] ? r_rf[rd_a1] : '0;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_result       = r_out;
    assign o_stat.halted  = r_halt;
    assign o_stat.pending = r_pend;

endmodule

// ----- rtl/universal_machine_execute_core.sv -----
// Top level of the universal machine execute core: front end, queue, back end.
//
//  channel | dir | tdata                                  | tuser
//  --------+-----+----------------------------------------+--------------
//  s_*     | in  | instr_word, reply_value                | action
//  m_*     | out | segment_id, segment_offset,            | request_kind
//          |     | store_value, next_pc, halted_flag,     |
//          |     | divide_by_zero, awaiting_reply         |
//
// Sequence: an instruction passes through a register file read, then execute;
// store adds the S_STORE state, since the register file has two read ports;
// divide waits in S_DIV for the radix-2 divider.
// The front end is registered; it and the two-entry queue keep taking transfers
// while the back end works or the result waits.
// Reset is synchronous, active low: it clears the PC, halt latch, pending reply,
// the register file valid bits, the queue and both valid flags.
// A stalled result holds the back end; the queue then fills and drops s_tready.
module universal_machine_execute_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [umec_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] instr_word, [63:32] reply_value
    input  logic                           s_tuser,  // [0] action
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [umec_pkg::M_TDATA_W-1:0] m_tdata,  // [31:0] segment_id, [63:32] segment_offset,
                                                     // [95:64] store_value, [127:96] next_pc,
                                                     // [128] halted_flag, [129] divide_by_zero,
                                                     // [130] awaiting_reply, [135:131] zero
    output logic [umec_pkg::KIND_W-1:0]    m_tuser   // [3:0] request_kind
);
    import umec_pkg::*;

    t_item   front_item;
    t_item   q_item;
    t_qstat  q_stat;
    logic    q_push;
    logic    q_pop;
    t_result result;
    t_bstat  back_stat;

    // accept and decode
    umec_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .i_qstat  (q_stat),
        .o_push   (q_push),
        .o_item   (front_item)
    );

    // decouple front and back
    umec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    // execute, hold machine state, drive the result register
    umec_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qstat  (q_stat),
        .i_item   (q_item),
        .o_pop    (q_pop),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_result (result),
        .o_stat   (back_stat)
    );

    // pack the result, first field in the lowest bits
    assign m_tuser = result.kind;
    assign m_tdata = {5'd0, result.awaiting, result.dz, result.halted,
                      result.pc, result.sval, result.soff, result.sid};

`ifndef SYNTHESIS
    // the front end never pushes into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("push into full queue");

    // the halt latch only falls through reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(back_stat.halted)) |-> back_stat.halted)
        else $error("halt latch cleared");

    // a request that expects a reply leaves the core waiting for it
    a_reply_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (m_tuser == K_LOAD || m_tuser == K_MAP || m_tuser == K_IN))
        |-> (m_tdata[130] && back_stat.pending))
        else $error("reply request without pending reply");
`endif

endmodule
